// ===== rtl/cbc_pkg.sv =====
// cbc_pkg: shared constants, types and register codes for the cartridge bank controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package cbc_pkg;

  // Geometry
  localparam int RAM_BANKS_DEF = 16;
  localparam int RAM_BANK_W    = 4;      // width of the ram_bank register
  localparam int RAM_OFF_W     = 13;     // 8 KiB per RAM bank
  localparam int ROM_BANK_W    = 9;
  localparam int ROM_OFF_W     = 14;     // 16 KiB per ROM bank
  localparam int ROM_AW        = 23;
  localparam int Q_DEPTH_DEF   = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [4:0] ROM_LOG2_MIN   = 5'd15;
  localparam logic [4:0] ROM_LOG2_MAX   = 5'd23;
  localparam logic [4:0] ROM_LOG2_RESET = 5'd23;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROM_SIZE_LOG2 = 1'b0,
    REG_SAVE_ENABLE   = 1'b1
  } cfg_reg_t;

  // Bus map
  localparam logic [15:0] ADDR_ENABLE_HI   = 16'h1FFF;
  localparam logic [15:0] ADDR_ROM_LO_HI   = 16'h2FFF;
  localparam logic [15:0] ADDR_ROM_HI_HI   = 16'h3FFF;
  localparam logic [15:0] ADDR_RAM_BANK_HI = 16'h5FFF;
  localparam logic [15:0] ADDR_ROM_HI      = 16'h7FFF;
  localparam logic [15:0] ADDR_ROMX_LO     = 16'h4000;
  localparam logic [15:0] ADDR_RAM_LO      = 16'hA000;
  localparam logic [15:0] ADDR_RAM_HI      = 16'hBFFF;

  localparam logic [3:0] NIBBLE_MASK    = 4'b1111;
  localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
  localparam logic [7:0] OPEN_BUS       = 8'hFF;
  localparam logic [ROM_BANK_W-1:0] ROM_BANK_RESET = ROM_BANK_W'(1);

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_RAM_RD = 2'd1,
    OP_RAM_WR = 2'd2
  } ram_op_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] rom_size_log2;
    logic                  save_enable;
  } cfg_t;

  // One classified item on its way from the front to the back.
  // Its data is the write byte for OP_RAM_WR, the finished read_data for OP_NONE.
  typedef struct packed {
    ram_op_t               op;
    logic [RAM_BANK_W-1:0] ram_bank;
    logic [RAM_OFF_W-1:0]  ram_offset;
    logic [7:0]            data;
    logic                  rom_fetch;
    logic [ROM_AW-1:0]     rom_address;
    logic                  save_request;
  } cmd_t;

endpackage

// ===== rtl/cartridge_bank_controller.sv =====
// cartridge_bank_controller: top level of the banked cartridge mapper.
// Depends on cbc_pkg, cbc_front, cbc_queue and cbc_back.
`timescale 1ns / 1ps
// Usage
//   Input channel (in_valid/in_ready): one CPU bus access per item, func 0 = read,
//   1 = write, with address and write_data.
//   Output channel (out_valid/out_ready): exactly one result item per input item,
//   in order: read_data, rom_fetch/rom_address for ROM reads, save_request when
//   dirty RAM is disabled with saves enabled.
//   Config port (cfg_write_enable/cfg_index/cfg_data): index 0 rom_size_log2,
//   index 1 save_enable; write only while no item is in flight.
// Timing
//   An accepted item passes a queue slot, then the RAM access into the output
//   register. Throughput one item per cycle while out_ready is high; the single
//   port of the save RAM sets that figure (one read or write per cycle).
// Reset
//   rst clears the bank registers and starts a clearing pass over the save RAM,
//   RAM_BANKS * 8192 entries (131072 by default); in_ready stays low meanwhile.
//   Config writes are taken during the pass.
// Stall
//   When out_ready is low the result holds in the output register and new items
//   still fill the 2-entry queue; in_ready drops only on a full queue or clearing.
module cartridge_bank_controller #(
  parameter int RAM_BANKS = cbc_pkg::RAM_BANKS_DEF,
  parameter int Q_DEPTH   = cbc_pkg::Q_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            func,
  input  logic [15:0]                     address,
  input  logic [7:0]                      write_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      read_data,
  output logic                            rom_fetch,
  output logic [cbc_pkg::ROM_AW-1:0]      rom_address,
  output logic                            save_request,
  input  logic                            cfg_write_enable,
  input  logic [cbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cbc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cbc_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  cmd_t q_head;
  logic q_ready, q_valid, q_pop;
  logic clearing;
  logic accept;

  // item accepted only when the queue has room and the RAM clear is done
  assign in_ready = q_ready && !clearing;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rom_size_log2 <= ROM_LOG2_RESET;
      cfg.save_enable   <= 1'b1;
    end else if (cfg_write_enable) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROM_SIZE_LOG2: cfg.rom_size_log2 <= cfg_data;
        REG_SAVE_ENABLE:   cfg.save_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // front: decode and bank state
  cbc_front #(.RAM_BANKS(RAM_BANKS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .func       (func),
    .address    (address),
    .write_data (write_data),
    .cmd        (cmd)
  );

  cbc_queue #(.DEPTH(Q_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (cmd),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .head       (q_head)
  );

  // back: save RAM and output register
  cbc_back #(.RAM_BANKS(RAM_BANKS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .clearing     (clearing),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data),
    .rom_fetch    (rom_fetch),
    .rom_address  (rom_address),
    .save_request (save_request)
  );

endmodule

// ===== rtl/cbc_front.sv =====
// cbc_front: decodes each accepted bus access, owns the bank/enable/dirty registers
// and builds the command for the back end. Depends on cbc_pkg.
`timescale 1ns / 1ps
module cbc_front #(
  parameter int RAM_BANKS = cbc_pkg::RAM_BANKS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  cbc_pkg::cfg_t cfg,
  input  logic          accept,
  input  logic          func,
  input  logic [15:0]   address,
  input  logic [7:0]    write_data,
  output cbc_pkg::cmd_t cmd
);
  import cbc_pkg::*;

  localparam int NB = 1 << RAM_BANK_W;

  logic [ROM_BANK_W-1:0] rom_bank, rom_bank_next;
  logic [RAM_BANK_W-1:0] ram_bank, ram_bank_next;
  logic                  ram_enabled, ram_enabled_next;
  logic                  ram_dirty, ram_dirty_next;

  // bank number modulo RAM_BANKS, as a constant table
  logic [RAM_BANK_W-1:0] bank_wrap [NB];
  for (genvar g = 0; g < NB; g++) begin : g_wrap
    assign bank_wrap[g] = RAM_BANK_W'(g % RAM_BANKS);
  end

  logic [4:0]        lg;
  logic [ROM_AW:0]   mask_wide;
  logic [ROM_AW-1:0] phys;
  logic              in_ram;
  logic              new_en;

  always_comb begin
    priority if (cfg.rom_size_log2 < ROM_LOG2_MIN) lg = ROM_LOG2_MIN;
    else if (cfg.rom_size_log2 > ROM_LOG2_MAX)    lg = ROM_LOG2_MAX;
    else                                          lg = cfg.rom_size_log2;
    mask_wide = ((ROM_AW+1)'(1) << lg) - (ROM_AW+1)'(1);
    if (address < ADDR_ROMX_LO) phys = ROM_AW'(address);
    else                        phys = {rom_bank, address[ROM_OFF_W-1:0]};

    in_ram = (address >= ADDR_RAM_LO) && (address <= ADDR_RAM_HI);
    new_en = (write_data[3:0] & NIBBLE_MASK) == RAM_ENABLE_KEY;

    rom_bank_next    = rom_bank;
    ram_bank_next    = ram_bank;
    ram_enabled_next = ram_enabled;
    ram_dirty_next   = ram_dirty;

    cmd              = '0;
    cmd.op           = OP_NONE;
    cmd.ram_bank     = ram_bank;
    cmd.ram_offset   = address[RAM_OFF_W-1:0];

    if (!func) begin
      priority if (address <= ADDR_ROM_HI) begin
        cmd.rom_fetch   = 1'b1;
        cmd.rom_address = phys & mask_wide[ROM_AW-1:0];
      end else if (in_ram && ram_enabled) begin
        cmd.op = OP_RAM_RD;
      end else begin
        cmd.data = OPEN_BUS;
      end
    end else begin
      priority if (address <= ADDR_ENABLE_HI) begin
        ram_enabled_next = new_en;
        if (ram_enabled && !new_en && ram_dirty && cfg.save_enable) begin
          ram_dirty_next   = 1'b0;
          cmd.save_request = 1'b1;
        end
      end else if (address <= ADDR_ROM_LO_HI) begin
        rom_bank_next = {rom_bank[ROM_BANK_W-1], write_data};
      end else if (address <= ADDR_ROM_HI_HI) begin
        rom_bank_next = {write_data[0], rom_bank[ROM_BANK_W-2:0]};
      end else if (address <= ADDR_RAM_BANK_HI) begin
        // stored already wrapped; only the wrapped value is ever used
        ram_bank_next = bank_wrap[write_data[RAM_BANK_W-1:0]];
      end else if (in_ram && ram_enabled) begin
        cmd.op         = OP_RAM_WR;
        cmd.data       = write_data;
        ram_dirty_next = 1'b1;
      end else begin
        cmd.op = OP_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank    <= ROM_BANK_RESET;
      ram_bank    <= '0;
      ram_enabled <= 1'b0;
      ram_dirty   <= 1'b0;
    end else if (accept) begin
      rom_bank    <= rom_bank_next;
      ram_bank    <= ram_bank_next;
      ram_enabled <= ram_enabled_next;
      ram_dirty   <= ram_dirty_next;
    end
  end

endmodule

// ===== rtl/cbc_queue.sv =====
// cbc_queue: short command FIFO between front and back end.
// Depends on cbc_pkg (cmd_t).
`timescale 1ns / 1ps
module cbc_queue #(
  parameter int DEPTH = cbc_pkg::Q_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cbc_pkg::cmd_t push_data,
  output logic          push_ready,
  input  logic          pop,
  output logic          pop_valid,
  output cbc_pkg::cmd_t head
);
  import cbc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign head       = entries[rd_ptr];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

endmodule

// ===== rtl/cbc_back.sv =====
// cbc_back: save RAM, its clearing pass after reset, and the output stage.
// Depends on cbc_pkg.
`timescale 1ns / 1ps
module cbc_back #(
  parameter int RAM_BANKS = cbc_pkg::RAM_BANKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  cbc_pkg::cmd_t               q_head,
  output logic                        q_pop,
  output logic                        clearing,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  read_data,
  output logic                        rom_fetch,
  output logic [cbc_pkg::ROM_AW-1:0]  rom_address,
  output logic                        save_request
);
  import cbc_pkg::*;

  localparam int BANK_W    = (RAM_BANKS > 1) ? $clog2(RAM_BANKS) : 1;
  localparam int RAM_AW    = BANK_W + RAM_OFF_W;
  localparam int RAM_DEPTH = RAM_BANKS << RAM_OFF_W;

  logic [7:0]        mem [RAM_DEPTH];
  logic [7:0]        mem_q;
  logic [RAM_AW-1:0] clr_addr;
  logic [RAM_AW-1:0] mem_addr;
  logic              mem_we, mem_re;
  logic [7:0]        mem_wd;

  logic              s1_valid;
  logic              s1_ram_rd;
  logic [7:0]        s1_data;
  logic              s1_fetch;
  logic [ROM_AW-1:0] s1_rom_address;
  logic              s1_save;

  assign q_pop    = q_valid && !clearing && (!s1_valid || out_ready);
  assign mem_addr = clearing ? clr_addr
                             : {q_head.ram_bank[BANK_W-1:0], q_head.ram_offset};
  assign mem_we   = clearing || (q_pop && q_head.op == OP_RAM_WR);
  assign mem_re   = q_pop && q_head.op == OP_RAM_RD;
  assign mem_wd   = clearing ? 8'h00 : q_head.data;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    if (mem_re) mem_q <= mem[mem_addr];
  end

  // one entry per cycle after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == RAM_AW'(RAM_DEPTH - 1)) clearing <= 1'b0;
      clr_addr <= clr_addr + RAM_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (q_pop) begin
      s1_valid <= 1'b1;
    end else if (out_ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_ram_rd      <= q_head.op == OP_RAM_RD;
      s1_data        <= (q_head.op == OP_NONE) ? q_head.data : 8'h00;
      s1_fetch       <= q_head.rom_fetch;
      s1_rom_address <= q_head.rom_address;
      s1_save        <= q_head.save_request;
    end
  end

  assign out_valid    = s1_valid;
  assign read_data    = s1_ram_rd ? mem_q : s1_data;
  assign rom_fetch    = s1_fetch;
  assign rom_address  = s1_rom_address;
  assign save_request = s1_save;

endmodule

// ===== rtl/cbc_checker.sv =====
// cbc_checker: port-level assertions for cartridge_bank_controller, bound to the top.
// Depends on cbc_pkg.
`timescale 1ns / 1ps
module cbc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [7:0]                      read_data,
  input logic                            rom_fetch,
  input logic [cbc_pkg::ROM_AW-1:0]      rom_address,
  input logic                            save_request
);
  import cbc_pkg::*;

  // RAM clear runs right after reset, so nothing may be taken then
  a_no_accept_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("item path open right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data)
      && $stable(rom_address) && $stable(rom_fetch) && $stable(save_request))
    else $error("stalled result changed");

  a_rom_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && rom_fetch |-> read_data == 8'h00 && !save_request)
    else $error("ROM fetch with data or save request");

  a_no_rom_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rom_fetch |-> rom_address == '0)
    else $error("ROM address without ROM fetch");

  a_save_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && save_request |-> read_data == 8'h00)
    else $error("save request carries read data");

endmodule

bind cartridge_bank_controller cbc_checker u_cbc_checker (.*);

// ===== dv/tb_cartridge_bank_controller.sv =====
// tb_cartridge_bank_controller: self-checking testbench for the banked cartridge mapper.
// Depends on cbc_pkg and cartridge_bank_controller; shadow model of banks and save RAM.
`timescale 1ns / 1ps
module tb_cartridge_bank_controller;
  import cbc_pkg::*;

  localparam logic FUNC_READ   = 1'b0;
  localparam logic FUNC_WRITE  = 1'b1;
  localparam int   SRAM_BYTES  = RAM_BANKS_DEF * (1 << RAM_OFF_W);
  localparam int   CYCLE_LIMIT = 1_000_000;  // the clearing pass counts toward this limit
  localparam int   MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0]        read_data;
    logic              rom_fetch;
    logic [ROM_AW-1:0] rom_address;
    logic              save_request;
  } bus_result_t;

  // DUT signals; the inputs are all known from time zero
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  func = FUNC_READ;
  logic [15:0]           address = '0;
  logic [7:0]            write_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            read_data;
  logic                  rom_fetch;
  logic [ROM_AW-1:0]     rom_address;
  logic                  save_request;
  logic                  cfg_write_enable = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the mapper state and its registers
  logic [CFG_DATA_W-1:0] sh_rom_log2 = ROM_LOG2_RESET;
  logic                  sh_save_en = 1'b1;
  logic [ROM_BANK_W-1:0] sh_rom_bank = ROM_BANK_RESET;
  logic [RAM_BANK_W-1:0] sh_ram_bank = '0;
  logic                  sh_ram_on = 1'b0;
  logic                  sh_dirty = 1'b0;
  bit   [7:0]            sh_sram [SRAM_BYTES];  // bit type: starts cleared, like the DUT

  bus_result_t pending_results[$];
  int          errors = 0;
  int          cycles = 0;
  int          rx_hold_req = 0;   // long hold-off request, picked up by the receiver
  int          rx_stall = 0;
  bit          tx_steady = 1'b0;  // no sender gaps while set
  bit          rx_steady = 1'b0;  // no receiver stalls while set

  cartridge_bank_controller uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .address(address), .write_data(write_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .read_data(read_data), .rom_fetch(rom_fetch),
    .rom_address(rom_address), .save_request(save_request),
    .cfg_write_enable(cfg_write_enable), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop in case the pipeline hangs
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_cartridge_bank_controller NOT OK");
      $finish;
    end
  end

  // Shadow mapper: applies one bus access and returns the result it must produce.
  function automatic bus_result_t predict_access(logic f, logic [15:0] a, logic [7:0] d);
    bus_result_t       r;
    logic [4:0]        lg;
    logic [ROM_AW-1:0] phys;
    logic              was_on;
    int unsigned       mask;
    r = '0;
    if (f == FUNC_READ) begin
      if (a <= ADDR_ROM_HI) begin
        // clamp the ROM size to 32 KiB .. 8 MiB, then wrap by mask
        lg = sh_rom_log2;
        if (lg < ROM_LOG2_MIN) lg = ROM_LOG2_MIN;
        if (lg > ROM_LOG2_MAX) lg = ROM_LOG2_MAX;
        // switchable window: bank * 16 KiB + offset; bank 0 stays bank 0
        phys = (a >= ADDR_ROMX_LO) ? {sh_rom_bank, a[ROM_OFF_W-1:0]}
                                   : ROM_AW'(a[ROM_OFF_W-1:0]);
        mask = (32'd1 << lg) - 32'd1;
        r.rom_address = phys & mask[ROM_AW-1:0];
        r.rom_fetch   = 1'b1;
      end else if (a >= ADDR_RAM_LO && a <= ADDR_RAM_HI && sh_ram_on) begin
        // 4-bit bank over 16 banks: wrap is implicit
        r.read_data = sh_sram[{sh_ram_bank, a[RAM_OFF_W-1:0]}];
      end else begin
        r.read_data = OPEN_BUS;
      end
    end else begin
      if (a <= ADDR_ENABLE_HI) begin
        was_on    = sh_ram_on;
        sh_ram_on = (d[3:0] & NIBBLE_MASK) == RAM_ENABLE_KEY;
        // save only on an enabled->disabled edge with dirty data; dirty held if saves off
        if (was_on && !sh_ram_on && sh_dirty && sh_save_en) begin
          sh_dirty       = 1'b0;
          r.save_request = 1'b1;
        end
      end else if (a <= ADDR_ROM_LO_HI) begin
        sh_rom_bank[7:0] = d;
      end else if (a <= ADDR_ROM_HI_HI) begin
        sh_rom_bank[8] = d[0];
      end else if (a <= ADDR_RAM_BANK_HI) begin
        sh_ram_bank = d[RAM_BANK_W-1:0];
      end else if (a >= ADDR_RAM_LO && a <= ADDR_RAM_HI && sh_ram_on) begin
        sh_sram[{sh_ram_bank, a[RAM_OFF_W-1:0]}] = d;
        sh_dirty = 1'b1;
      end
    end
    return r;
  endfunction

  // Sender gaps: mostly back to back, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // RAM window address; half of them land on a few hot offsets so reads hit writes
  function automatic logic [15:0] pick_ram_addr();
    logic [RAM_OFF_W-1:0] off;
    if ($urandom_range(0, 1)) off = RAM_OFF_W'($urandom);
    else off = RAM_OFF_W'($urandom_range(0, 7)) | ($urandom_range(0, 1) ? 13'h1FF8 : 13'h0);
    return ADDR_RAM_LO | 16'(off);
  endfunction

  // Offer one item; entered and left at a falling edge.
  task automatic send_access(logic f, logic [15:0] a, logic [7:0] d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    func       <= f;
    address    <= a;
    write_data <= d;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    pending_results.push_back(predict_access(f, a, d));
    @(negedge clk);
  endtask

  // Drop valid and let every outstanding result drain, plus pipeline slack
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Register write; only called with nothing in flight
  task automatic set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
    cfg_write_enable <= 1'b1;
    cfg_index        <= idx;
    cfg_data         <= v;
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    @(negedge clk);
    if (idx == REG_ROM_SIZE_LOG2) sh_rom_log2 = v;
    else sh_save_en = v[0];
  endtask

  // Weighted mix: mostly meaningful accesses, some raw noise
  task automatic send_random_access();
    int          pick;
    logic        f;
    logic [15:0] a;
    logic [7:0]  d;
    pick = $urandom_range(0, 99);
    d    = 8'($urandom);
    f    = FUNC_WRITE;
    if (pick < 25) begin
      f = FUNC_READ;
      a = 16'($urandom_range(0, ADDR_ROM_HI));
    end else if (pick < 45) begin
      f = FUNC_READ;
      a = pick_ram_addr();
    end else if (pick < 65) begin
      a = pick_ram_addr();
    end else if (pick < 75) begin
      a = 16'($urandom_range(0, ADDR_ENABLE_HI));
      if ($urandom_range(0, 2) != 0) d[3:0] = RAM_ENABLE_KEY;  // enable more often than not
    end else if (pick < 85) begin
      a = 16'($urandom_range(ADDR_ENABLE_HI + 1, ADDR_ROM_HI_HI));
    end else if (pick < 92) begin
      a = 16'($urandom_range(ADDR_ROM_HI_HI + 1, ADDR_RAM_BANK_HI));
    end else begin
      f = 1'($urandom);
      a = 16'($urandom);
    end
    send_access(f, a, d);
  endtask

  // Receiver: random stalls, plus a long hold-off when a test asks for one
  always @(negedge clk) begin
    if (rx_hold_req > 0) begin
      rx_stall    = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_stall > 0) begin
      out_ready <= 1'b0;
      rx_stall--;
    end else begin
      out_ready <= 1'b1;
      if (!rx_steady) begin
        case ($urandom_range(0, 99)) inside
          [0:19]:  rx_stall = $urandom_range(1, 3);
          [20:22]: rx_stall = $urandom_range(10, 40);
          default: rx_stall = 0;
        endcase
      end
    end
  end

  task automatic report_mismatch(string what, bus_result_t want, bus_result_t got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t %s: expected rd=%02h fetch=%0b addr=%06h save=%0b,",
               $time, what, want.read_data, want.rom_fetch, want.rom_address,
               want.save_request,
               " got rd=%02h fetch=%0b addr=%06h save=%0b",
               got.read_data, got.rom_fetch, got.rom_address, got.save_request);
  endtask

  // Result checker: each accepted result against the oldest expectation
  always @(posedge clk) begin : check_results
    bus_result_t got;
    bus_result_t want;
    if (!rst && out_valid && out_ready) begin
      got = {read_data, rom_fetch, rom_address, save_request};
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.read_data !== want.read_data || got.rom_fetch !== want.rom_fetch ||
            got.rom_address !== want.rom_address || got.save_request !== want.save_request)
          report_mismatch("mismatch", want, got);
      end
    end
  end

  // ROM window decode, bank register halves, bank 0 and unmapped reads
  task automatic test_rom_reads();
    send_access(FUNC_READ,  16'h0000, 8'h00);
    send_access(FUNC_READ,  16'h7FFF, 8'h00);   // reset bank is 1
    send_access(FUNC_WRITE, 16'h2000, 8'hFF);
    send_access(FUNC_WRITE, 16'h3000, 8'h01);   // bank 0x1FF, top of 8 MiB
    send_access(FUNC_READ,  16'h4000, 8'h00);
    send_access(FUNC_WRITE, 16'h2FFF, 8'h00);
    send_access(FUNC_WRITE, 16'h3FFF, 8'hFE);   // bank 0 maps to bank 0
    send_access(FUNC_READ,  16'h7FFF, 8'hFF);
    send_access(FUNC_READ,  16'h8000, 8'h00);
    send_access(FUNC_READ,  16'hFFFF, 8'h00);
  endtask

  // RAM gating, top bank, bank wrap, ignored writes, save on disable
  task automatic test_ram_access();
    send_access(FUNC_READ,  16'hA000, 8'h00);   // disabled: open bus
    send_access(FUNC_WRITE, 16'hA000, 8'h77);   // disabled: dropped
    send_access(FUNC_WRITE, 16'h0000, 8'hFA);   // only the low nibble counts
    send_access(FUNC_WRITE, 16'h4000, 8'hFF);   // bank 15
    send_access(FUNC_WRITE, 16'hBFFF, 8'h5A);
    send_access(FUNC_READ,  16'hBFFF, 8'h00);
    send_access(FUNC_WRITE, 16'h5FFF, 8'h00);
    send_access(FUNC_READ,  16'hBFFF, 8'h00);   // bank 0 still cleared
    send_access(FUNC_WRITE, 16'h6000, 8'h12);   // unmapped write
    send_access(FUNC_WRITE, 16'h1FFF, 8'h0B);   // disable while dirty
  endtask

  // With saves off the dirty flag survives a disable and fires later
  task automatic test_save_enable();
    wait_idle();
    set_reg(REG_SAVE_ENABLE, 5'd0);
    send_access(FUNC_WRITE, 16'h0000, 8'h0A);
    send_access(FUNC_WRITE, 16'hB000, 8'h11);
    send_access(FUNC_WRITE, 16'h1000, 8'h00);   // no save, still dirty
    wait_idle();
    set_reg(REG_SAVE_ENABLE, 5'd1);
    send_access(FUNC_WRITE, 16'h0000, 8'h0A);
    send_access(FUNC_READ,  16'hB000, 8'h00);
    send_access(FUNC_WRITE, 16'h1000, 8'h00);   // save now
  endtask

  // Receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    wait_idle();
    tx_steady   = 1'b1;
    rx_hold_req = 60;
    repeat (12) send_random_access();
    tx_steady = 1'b0;
    wait_idle();   // sender pause until everything has drained
  endtask

  // Random traffic across several ROM sizes, out-of-range ones included
  task automatic test_random();
    logic [CFG_DATA_W-1:0] sizes[6] = '{5'd15, 5'd0, 5'd23, 5'd31, 5'd18, 5'd24};
    for (int i = 0; i < 6; i++) begin
      wait_idle();
      set_reg(REG_ROM_SIZE_LOG2, sizes[i]);
      // upper data bits are don't-care for this register
      set_reg(REG_SAVE_ENABLE, {4'($urandom), 1'(i % 2)});
      tx_steady = (i == 2);
      rx_steady = (i == 3);
      repeat (66) send_random_access();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    // block runs its RAM clearing pass now; the first item waits on in_ready
    test_rom_reads();
    test_ram_access();
    test_save_enable();
    test_backpressure();
    test_random();
    wait_idle();
    repeat (8) @(negedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_cartridge_bank_controller OK");
    end else begin
      $display("tb_cartridge_bank_controller NOT OK");
    end
    $finish;
  end

endmodule
